/* rtl/mfp_pkg.sv */
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants of the metaball field pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package mfp_pkg;

  localparam int unsigned BLOB_COUNT  = 3;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned PIX_W       = 6;
  localparam int unsigned NUMER_W     = 16;
  localparam int unsigned LAST_W      = 15;
  localparam int unsigned DIST_W      = 17;
  localparam int unsigned WEIGHT_W    = 8;
  localparam int unsigned QBITS       = 8;
  localparam int unsigned TRIAL_W     = LAST_W + QBITS;
  localparam int unsigned SUM_W       = 11;

  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT   = 8'd200;
  localparam logic [WEIGHT_W-1:0] INTENSITY_MAX = 8'd255;

  // lane latency: distance, index, overflow check, quotient bits, weight
  localparam int unsigned LANE_LAT    = 3 + QBITS + 1;

  localparam logic REG_RECIP_NUMERATOR  = 1'b0;
  localparam logic REG_TABLE_LAST_INDEX = 1'b1;

  localparam logic [NUMER_W-1:0] NUMER_RESET = 16'd4800;
  localparam logic [LAST_W-1:0]  LAST_RESET  = 15'd321;

  typedef struct packed {
    logic [NUMER_W-1:0] recip_numerator;
    logic [LAST_W-1:0]  table_last_index;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/mfp_lane.sv */
// ----------------------------------------------------------------------------
// mfp_lane
// Weight of one blob: squared distance, clamped index, pipelined quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_lane
  import mfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire cfg_t                cfg_i,
  input  wire logic [PIX_W-1:0]    col_i,
  input  wire logic [PIX_W-1:0]    row_i,
  input  wire logic [COORD_W-1:0]  bx_i,
  input  wire logic [COORD_W-1:0]  by_i,
  output logic      [WEIGHT_W-1:0] weight_o
);

  logic signed [DIST_W-2:0]    dx, dy;
  logic [DIST_W-2:0]           sqx, sqy;
  logic [DIST_W-1:0]           dist_d;
  logic [DIST_W-3:0]           dist_q;
  logic [LAST_W-1:0]           idx_d, idx_q;
  logic [TRIAL_W-1:0]          top_trial;

  logic [NUMER_W-1:0]  rem_q  [QBITS+1];
  logic [QBITS-1:0]    quo_q  [QBITS+1];
  logic [LAST_W-1:0]   div_q  [QBITS+1];
  logic                full_q [QBITS+1];

  logic [WEIGHT_W-1:0] weight_d, weight_q;

  assign dx     = $signed({{(DIST_W-1-COORD_W){bx_i[COORD_W-1]}}, bx_i})
                - $signed({{(DIST_W-1-PIX_W){1'b0}}, col_i});
  assign dy     = $signed({{(DIST_W-1-COORD_W){by_i[COORD_W-1]}}, by_i})
                - $signed({{(DIST_W-1-PIX_W){1'b0}}, row_i});
  assign sqx    = dx * dx;
  assign sqy    = dy * dy;
  assign dist_d = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d[DIST_W-1:2];
  end

  always_comb begin
    idx_d = dist_q;
    if (idx_d > cfg_i.table_last_index) begin
      idx_d = cfg_i.table_last_index;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // quotient of 256 or more, or a zero index, saturates to full weight
  assign top_trial = {idx_q, {QBITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= cfg_i.recip_numerator;
    quo_q[0]  <= '0;
    div_q[0]  <= idx_q;
    full_q[0] <= ({{(TRIAL_W-NUMER_W){1'b0}}, cfg_i.recip_numerator} >= top_trial);
  end

  for (genvar s = 0; s < QBITS; s++) begin : g_div
    localparam int unsigned B = QBITS - 1 - s;
    logic [TRIAL_W-1:0] trial;
    logic               ge;
    logic [QBITS-1:0]   quo_nxt;

    assign trial = {{QBITS{1'b0}}, div_q[s]} << B;
    assign ge    = ({{(TRIAL_W-NUMER_W){1'b0}}, rem_q[s]} >= trial);

    always_comb begin
      quo_nxt    = quo_q[s];
      quo_nxt[B] = ge;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? (rem_q[s] - trial[NUMER_W-1:0]) : rem_q[s];
      quo_q[s+1]  <= quo_nxt;
      div_q[s+1]  <= div_q[s];
      full_q[s+1] <= full_q[s];
    end
  end

  always_comb begin
    if (full_q[QBITS] || (quo_q[QBITS] > FULL_WEIGHT)) begin
      weight_d = FULL_WEIGHT;
    end else begin
      weight_d = quo_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q <= weight_d;
  end

  assign weight_o = weight_q;

endmodule

`default_nettype wire

/* rtl/mfp_merge.sv */
// ----------------------------------------------------------------------------
// mfp_merge
// Adds the fade level and all lane weights, saturates to eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_merge
  import mfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic [WEIGHT_W-1:0] fade_i,
  input  wire logic [WEIGHT_W-1:0] weight_i [BLOB_COUNT],
  output logic      [WEIGHT_W-1:0] intensity_o
);

  logic [SUM_W-1:0]    sum;
  logic [WEIGHT_W-1:0] int_d, int_q;

  always_comb begin
    sum = {{(SUM_W-WEIGHT_W){1'b0}}, fade_i};
    for (int k = 0; k < BLOB_COUNT; k++) begin
      sum = sum + {{(SUM_W-WEIGHT_W){1'b0}}, weight_i[k]};
    end
    if (sum > {{(SUM_W-WEIGHT_W){1'b0}}, INTENSITY_MAX}) begin
      int_d = INTENSITY_MAX;
    end else begin
      int_d = sum[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    int_q <= int_d;
  end

  assign intensity_o = int_q;

endmodule

`default_nettype wire

/* rtl/metaball_field_pixel.sv */
// ----------------------------------------------------------------------------
// metaball_field_pixel
// Field value of one grid pixel under three metaballs.
//
// A pixel beat is taken at each clock edge with start_i high and busy_o low;
// busy_o stays low, so a new pixel may enter on every cycle. Each beat
// carries the pixel column and row, three blob centres and a fade level.
// One lane per blob forms the squared distance, clamps the index and runs
// an eight-stage restoring quotient; a merge stage adds the fade level and
// the weights and saturates to 255.
// Throughput is one pixel per cycle, set by the fully pipelined lanes.
// intensity_o is valid for exactly one cycle while done_o is high; there is
// no back-pressure on the result side.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 recip_numerator, 1 table_last_index); write only while no pixel is in
// flight. Reset clears the pipeline valid bits and restores the registers
// to 4800 and 321.
// ----------------------------------------------------------------------------
`default_nettype none

module metaball_field_pixel
  import mfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [NUMER_W-1:0] cfg_wdata_i,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [PIX_W-1:0]   pixel_col_i,
  input  wire logic [PIX_W-1:0]   pixel_row_i,
  input  wire logic [COORD_W-1:0] blob_a_x_i,
  input  wire logic [COORD_W-1:0] blob_a_y_i,
  input  wire logic [COORD_W-1:0] blob_b_x_i,
  input  wire logic [COORD_W-1:0] blob_b_y_i,
  input  wire logic [COORD_W-1:0] blob_c_x_i,
  input  wire logic [COORD_W-1:0] blob_c_y_i,
  input  wire logic [WEIGHT_W-1:0] fade_level_i,
  output logic                    done_o,
  output logic [WEIGHT_W-1:0]     intensity_o
);

  localparam int unsigned FADE_DEPTH = LANE_LAT + 1;
  localparam int unsigned VLD_DEPTH  = LANE_LAT + 2;

  cfg_t                cfg_q;
  logic                accept;
  logic [VLD_DEPTH-1:0] vld_q;

  logic [PIX_W-1:0]    col_q, row_q;
  logic [COORD_W-1:0]  bx_in [BLOB_COUNT];
  logic [COORD_W-1:0]  by_in [BLOB_COUNT];
  logic [COORD_W-1:0]  bx_q  [BLOB_COUNT];
  logic [COORD_W-1:0]  by_q  [BLOB_COUNT];
  logic [WEIGHT_W-1:0] fade_q [FADE_DEPTH];
  logic [WEIGHT_W-1:0] weight [BLOB_COUNT];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recip_numerator  <= NUMER_RESET;
      cfg_q.table_last_index <= LAST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RECIP_NUMERATOR:  cfg_q.recip_numerator  <= cfg_wdata_i;
        REG_TABLE_LAST_INDEX: cfg_q.table_last_index <= cfg_wdata_i[LAST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLD_DEPTH-2:0], accept};
    end
  end

  assign bx_in[0] = blob_a_x_i;
  assign by_in[0] = blob_a_y_i;
  assign bx_in[1] = blob_b_x_i;
  assign by_in[1] = blob_b_y_i;
  assign bx_in[2] = blob_c_x_i;
  assign by_in[2] = blob_c_y_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q     <= pixel_col_i;
      row_q     <= pixel_row_i;
      bx_q      <= bx_in;
      by_q      <= by_in;
      fade_q[0] <= fade_level_i;
    end
    for (int k = 1; k < FADE_DEPTH; k++) begin
      fade_q[k] <= fade_q[k-1];
    end
  end

  for (genvar g = 0; g < BLOB_COUNT; g++) begin : g_lane
    mfp_lane u_lane (
      .clk_i    (clk_i),
      .cfg_i    (cfg_q),
      .col_i    (col_q),
      .row_i    (row_q),
      .bx_i     (bx_q[g]),
      .by_i     (by_q[g]),
      .weight_o (weight[g])
    );
  end

  mfp_merge u_merge (
    .clk_i       (clk_i),
    .fade_i      (fade_q[FADE_DEPTH-1]),
    .weight_i    (weight),
    .intensity_o (intensity_o)
  );

  assign done_o = vld_q[VLD_DEPTH-1];

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the metaball field pixel block.
//
// Pixel beats go in as bursts with random gaps between them. A scoreboard
// object keeps its own copy of the two registers. For every accepted pixel
// it works out the field intensity: squared distance to each blob, index
// clamp, capped quotient weight, fade, saturation. Each done_o beat is
// compared with the oldest prediction. The register settings change between
// phases while the pipeline is empty. They cover zero and full-scale
// numerators, a zero last index and a last index written with all ones.
// ----------------------------------------------------------------------------

module tb_top;
  import mfp_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]                   col;
    logic [PIX_W-1:0]                   row;
    logic [BLOB_COUNT-1:0][COORD_W-1:0] bx;
    logic [BLOB_COUNT-1:0][COORD_W-1:0] by;
    logic [WEIGHT_W-1:0]                fade;
  } pixel_t;

  class intensity_board;
    logic [NUMER_W-1:0]  numer;
    logic [LAST_W-1:0]   last_idx;
    logic [WEIGHT_W-1:0] intensity_q[$];
    int unsigned         errors;

    function new();
      numer    = NUMER_RESET;
      last_idx = LAST_RESET;
      errors   = 0;
    endfunction

    function void write_reg(logic idx, logic [NUMER_W-1:0] data);
      case (idx)
        REG_RECIP_NUMERATOR:  numer    = data;
        REG_TABLE_LAST_INDEX: last_idx = data[LAST_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned blob_weight(logic signed [COORD_W-1:0] cx,
                                      logic signed [COORD_W-1:0] cy,
                                      logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      int          dx;
      int          dy;
      int unsigned idx;
      int unsigned q;
      dx  = int'(cx) - int'(col);
      dy  = int'(cy) - int'(row);
      idx = int'(dx * dx + dy * dy) >> 2;
      if (idx > 32'(last_idx)) idx = 32'(last_idx);
      if (idx == 0) return 32'(FULL_WEIGHT);
      q = 32'(numer) / idx;
      return (q < 32'(FULL_WEIGHT)) ? q : 32'(FULL_WEIGHT);
    endfunction

    function logic [WEIGHT_W-1:0] field_value(pixel_t p);
      int unsigned sum;
      sum = 32'(p.fade);
      for (int k = 0; k < BLOB_COUNT; k++) begin
        sum += blob_weight(p.bx[k], p.by[k], p.col, p.row);
      end
      return (sum > 32'(INTENSITY_MAX)) ? INTENSITY_MAX : sum[WEIGHT_W-1:0];
    endfunction

    function void note_pixel(pixel_t p);
      intensity_q.push_back(field_value(p));
    endfunction

    function void check_intensity(logic [WEIGHT_W-1:0] got);
      logic [WEIGHT_W-1:0] want;
      if (intensity_q.size() == 0) begin
        $error("intensity: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = intensity_q.pop_front();
      if (got !== want) begin
        $error("intensity: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic                cfg_idx_i    = REG_RECIP_NUMERATOR;
  logic [NUMER_W-1:0]  cfg_wdata_i  = '0;
  logic                start_i      = 1'b0;
  logic                busy_o;
  logic [PIX_W-1:0]    pixel_col_i  = '0;
  logic [PIX_W-1:0]    pixel_row_i  = '0;
  logic [COORD_W-1:0]  blob_a_x_i   = '0;
  logic [COORD_W-1:0]  blob_a_y_i   = '0;
  logic [COORD_W-1:0]  blob_b_x_i   = '0;
  logic [COORD_W-1:0]  blob_b_y_i   = '0;
  logic [COORD_W-1:0]  blob_c_x_i   = '0;
  logic [COORD_W-1:0]  blob_c_y_i   = '0;
  logic [WEIGHT_W-1:0] fade_level_i = '0;
  logic                done_o;
  logic [WEIGHT_W-1:0] intensity_o;

  intensity_board sb = new();

  metaball_field_pixel dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin : beat_monitor
    pixel_t seen;
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (start_i && !busy_o) begin
        seen.col  = pixel_col_i;
        seen.row  = pixel_row_i;
        seen.bx   = {blob_c_x_i, blob_b_x_i, blob_a_x_i};
        seen.by   = {blob_c_y_i, blob_b_y_i, blob_a_y_i};
        seen.fade = fade_level_i;
        sb.note_pixel(seen);
      end
      if (done_o) sb.check_intensity(intensity_o);
    end
  end

  function automatic pixel_t make_pixel(int col, int row, int ax, int ay, int bx, int by,
                                        int cx, int cy, int fade);
    pixel_t p;
    p.col  = col[PIX_W-1:0];
    p.row  = row[PIX_W-1:0];
    p.bx   = {8'(cx), 8'(bx), 8'(ax)};
    p.by   = {8'(cy), 8'(by), 8'(ay)};
    p.fade = fade[WEIGHT_W-1:0];
    return p;
  endfunction

  // mostly near the pixel so the weights spread out, sometimes anywhere
  function automatic logic [COORD_W-1:0] blob_coord(int p);
    int v;
    case ($urandom_range(0, 7))
      0:       v = p;
      1, 2:    v = p + int'($urandom_range(0, 8)) - 4;
      3, 4:    v = p + int'($urandom_range(0, 40)) - 20;
      default: return COORD_W'($urandom_range(0, 255));
    endcase
    return v[COORD_W-1:0];
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.col = PIX_W'($urandom_range(0, 63));
    p.row = PIX_W'($urandom_range(0, 63));
    for (int k = 0; k < BLOB_COUNT; k++) begin
      p.bx[k] = blob_coord(int'(p.col));
      p.by[k] = blob_coord(int'(p.row));
    end
    p.fade = ($urandom_range(0, 1) != 0) ? WEIGHT_W'($urandom_range(0, 255))
                                         : WEIGHT_W'($urandom_range(0, 40));
    return p;
  endfunction

  task automatic send_pixel(pixel_t p);
    start_i      <= 1'b1;
    pixel_col_i  <= p.col;
    pixel_row_i  <= p.row;
    blob_a_x_i   <= p.bx[0];
    blob_a_y_i   <= p.by[0];
    blob_b_x_i   <= p.bx[1];
    blob_b_y_i   <= p.by[1];
    blob_c_x_i   <= p.bx[2];
    blob_c_y_i   <= p.by[2];
    fade_level_i <= p.fade;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic run_pixels(input pixel_t batch[$]);
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    foreach (batch[n]) begin
      send_pixel(batch[n]);
      burst--;
      if (burst == 0 && n != batch.size() - 1) begin
        gap = $urandom_range(1, 6);
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      end
    end
    start_i <= 1'b0;
    while (sb.intensity_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  logic [NUMER_W-1:0] numer_set[7] = '{16'd0, 16'd4800, 16'hFFFF, 16'd1200, 16'd1,
                                       16'd0, 16'd4800};
  logic [NUMER_W-1:0] last_set[7]  = '{16'd321, 16'd0, 16'hFFFF, 16'd321, 16'd1,
                                       16'd0, 16'd321};

  initial begin : stimulus
    pixel_t             batch[$];
    logic [NUMER_W-1:0] numer;
    logic [NUMER_W-1:0] last_w;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    batch.push_back(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
    batch.push_back(make_pixel(63, 63, -128, -128, -128, -128, -128, -128, 0));
    batch.push_back(make_pixel(63, 63, -128, -128, -128, -128, -128, -128, 255));
    batch.push_back(make_pixel(63, 0, 63, 0, -128, 127, 127, -128, 0));
    batch.push_back(make_pixel(0, 63, 1, 63, 2, 63, 0, 61, 10));
    batch.push_back(make_pixel(32, 32, 127, 127, -1, -1, 32, 40, 55));
    batch.push_back(make_pixel(10, 20, 10, 20, 40, 20, 10, -20, 0));
    batch.push_back(make_pixel(63, 63, 127, 127, 127, -128, -128, 127, 128));
    batch.push_back(make_pixel(42, 21, 85, -86, -86, 85, 85, 85, 170));
    batch.push_back(make_pixel(21, 42, -86, 85, 85, -86, -86, -86, 85));
    batch.push_back(make_pixel(5, 5, 5, 5, 5, 5, 5, 5, 255));
    batch.push_back(make_pixel(0, 0, 127, 127, 127, 127, 127, 127, 0));
    repeat (230) batch.push_back(random_pixel());
    run_pixels(batch);

    for (int ph = 0; ph < 7; ph++) begin
      numer  = numer_set[ph];
      last_w = last_set[ph];
      if (ph == 5) begin
        numer  = NUMER_W'($urandom_range(0, 16'hFFFF));
        last_w = NUMER_W'($urandom_range(0, 16'hFFFF));
      end
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_RECIP_NUMERATOR;
      cfg_wdata_i <= numer;
      @(posedge clk_i);
      cfg_idx_i   <= REG_TABLE_LAST_INDEX;
      cfg_wdata_i <= last_w;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      batch.delete();
      repeat (235) batch.push_back(random_pixel());
      run_pixels(batch);
    end

    repeat (LANE_LAT + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
